// ===== sv/sound_log_command_parser_macros.svh =====
// assertion macros for the sound log command parser
`ifndef SOUND_LOG_COMMAND_PARSER_MACROS_SVH
`define SOUND_LOG_COMMAND_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define SLCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SLCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SLCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLCP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/slcp_pkg.sv =====
// types, opcode constants and decode functions for the sound log command parser
package slcp_pkg;

	localparam logic [7:0] OP_WAIT_N     = 8'h61;
	localparam logic [7:0] OP_WAIT_735   = 8'h62;
	localparam logic [7:0] OP_WAIT_882   = 8'h63;
	localparam logic [7:0] OP_END        = 8'h66;
	localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
	localparam logic [7:0] OP_PWM        = 8'hB2;

	localparam logic [15:0] WAIT_NTSC    = 16'd735;
	localparam logic [15:0] WAIT_PAL     = 16'd882;
	localparam logic [15:0] PWM_MASK     = 16'h0FFF;
	localparam logic [7:0]  PORT_MASK    = 8'h7F;
	localparam logic [7:0]  NIBBLE_MASK  = 8'h0F;

	localparam int TDATA_W = 88;

	typedef struct packed {
		logic       valid;
		logic [5:0] code;
	} chip_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [15:0] data_word;
		logic [7:0]  data_byte;
		logic [7:0]  reg_address;
		logic [6:0]  chip_port;
		logic        chip_instance;
		logic [5:0]  chip_code;
		logic [7:0]  command_code;
		logic [31:0] event_tick;
	} event_t;

	function automatic logic [3:0] cmd_len(input logic [7:0] op);
		logic [3:0] len;
		if (op < 8'h20) len = 4'd1;
		else if (op == 8'h20 || op == 8'h22) len = 4'd3;
		else if (op < 8'h40) len = 4'd2;
		else if (op < 8'h4F) len = 4'd3;
		else if (op <= 8'h50) len = 4'd2;
		else if (op < 8'h60) len = 4'd3;
		else if (op == OP_WAIT_N) len = 4'd3;
		else if (op == OP_DATA_BLOCK) len = 4'd7;
		else if (op == 8'h68) len = 4'd12;
		else if (op < 8'h90) len = 4'd1;
		else if (op == 8'h90) len = 4'd3;
		else if (op == 8'h93) len = 4'd4;
		else if (op == 8'h95) len = 4'd5;
		else if (op < 8'h95) len = 4'd2;
		else if (op < 8'hA0) len = 4'd1;
		else if (op < 8'hC0) len = 4'd3;
		else if (op < 8'hC3) len = 4'd5;
		else if (op < 8'hC9) len = 4'd4;
		else if (op < 8'hD0) len = 4'd1;
		else if (op < 8'hD3) len = 4'd4;
		else if (op < 8'hD7) len = 4'd5;
		else if (op == 8'hE0 || op == 8'hE1) len = 4'd5;
		else len = 4'd1;
		return len;
	endfunction

	function automatic logic [5:0] ym_family(input logic [3:0] lo);
		logic [5:0] c;
		unique case (lo)
			4'h1: c = 6'd2;
			4'h2, 4'h3: c = 6'd3;
			4'h4: c = 6'd4;
			4'h5: c = 6'd5;
			4'h6, 4'h7: c = 6'd6;
			4'h8, 4'h9: c = 6'd7;
			4'hA: c = 6'd8;
			4'hB: c = 6'd9;
			4'hC: c = 6'd10;
			4'hD: c = 6'd11;
			4'hE, 4'hF: c = 6'd12;
			default: c = 6'd0;
		endcase
		return c;
	endfunction

	function automatic chip_t chip_of(input logic [7:0] op);
		chip_t ch;
		ch.valid = 1'b1;
		ch.code  = 6'd0;
		if ((op >= 8'h51 && op <= 8'h5F) || (op >= 8'hA1 && op <= 8'hAF)) begin
			ch.code = ym_family(op[3:0]);
		end else if (op[7:4] == 4'h8) begin
			ch.code = 6'd3;
		end else if (op[7:4] == 4'hB) begin
			ch.code = (op[3:0] == 4'h0) ? 6'd13 : 6'd12 + {2'b00, op[3:0]};
		end else begin
			unique case (op)
				8'h20, 8'h31, 8'hA0: ch.code = 6'd0;
				8'h30, 8'h3F, 8'h4F, 8'h50: ch.code = 6'd1;
				8'hC0: ch.code = 6'd28;
				8'hC1, 8'hC2: ch.code = 6'd13;
				8'hC3: ch.code = 6'd17;
				8'hC4: ch.code = 6'd26;
				8'hC5, 8'hD3: ch.code = 6'd29;
				8'hC6, 8'hD4: ch.code = 6'd30;
				8'hC7: ch.code = 6'd31;
				8'hC8: ch.code = 6'd22;
				8'hD0: ch.code = 6'd32;
				8'hD1: ch.code = 6'd33;
				8'hD2: ch.code = 6'd34;
				8'hE0: ch.code = 6'd3;
				8'hE1: ch.code = 6'd35;
				default: ch.valid = 1'b0;
			endcase
		end
		return ch;
	endfunction

endpackage

// ===== sv/sound_log_command_parser.sv =====
// sound log command parser: byte stream in, register-write events out
// path: an accepted byte is held in the input register, then its event is written to the event register
// throughput: one byte per cycle, set by the single decode stage between the
//   input register and the event register; a held event stalls the input register
// reset: arst_n clears the parser state, except the operand bytes, asynchronously; a byte with tlast also
//   returns the parser to its reset state after that byte is handled
`include "sound_log_command_parser_macros.svh"

module sound_log_command_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // stream_byte
	input  logic                         s_axis_tlast,  // final_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// event_tick, command_code, chip_code, chip_instance, chip_port,
	// reg_address, data_byte, data_word, zero fill
	output logic [slcp_pkg::TDATA_W-1:0] m_axis_tdata
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [3:0]       phase_q, phase_d, phase_inc;
	logic [7:0]       held_q, held_d;
	logic [3:0][7:0]  ops_q, ops_d;
	logic [31:0]      skip_q, skip_d;
	logic [31:0]      tick_q, tick_d;
	logic             ended_q, ended_d;

	logic             advance;
	logic             exec_en;
	logic [7:0]       exec_op;
	logic [3:0]       exec_len;
	slcp_pkg::chip_t  chip;
	logic [15:0]      tick_inc;
	logic             emit;
	slcp_pkg::event_t ev;

	logic             out_valid_q;
	slcp_pkg::event_t out_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// command sequencing
	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		ops_d     = ops_q;
		skip_d    = skip_q;
		ended_d   = ended_q;
		exec_en   = 1'b0;
		exec_op   = held_q;
		phase_inc = phase_q + 4'd1;
		if (ended_q) begin
			phase_d = phase_q;
		end else if (skip_q != 32'd0) begin
			skip_d = skip_q - 32'd1;
		end else if (phase_q == 4'd0) begin
			if (slcp_pkg::cmd_len(byte_s1) == 4'd1) begin
				exec_en = 1'b1;
				exec_op = byte_s1;
			end else begin
				held_d  = byte_s1;
				phase_d = 4'd1;
			end
		end else begin
			if (held_q == slcp_pkg::OP_DATA_BLOCK) begin
				if (phase_q >= 4'd3) begin
					ops_d[phase_q[1:0] - 2'd3] = byte_s1;
				end
			end else if (phase_q <= 4'd4) begin
				ops_d[phase_q[1:0] - 2'd1] = byte_s1;
			end
			if (phase_inc >= slcp_pkg::cmd_len(held_q)) begin
				phase_d = 4'd0;
				exec_en = 1'b1;
			end else begin
				phase_d = phase_inc;
			end
		end
	end

	// command execution
	always_comb begin
		exec_len         = slcp_pkg::cmd_len(exec_op);
		chip             = slcp_pkg::chip_of(exec_op);
		tick_inc         = 16'd0;
		emit             = 1'b0;
		ev               = '0;
		ev.event_tick    = tick_q;
		ev.command_code  = exec_op;
		ev.chip_code     = chip.code;
		ev.chip_instance = (exec_op >= 8'hA1 && exec_op <= 8'hAF) || (exec_op[7:4] == 4'h3);
		unique case (exec_len)
			4'd2: ev.data_byte = ops_d[0];
			4'd3: begin
				ev.reg_address = ops_d[0];
				ev.data_byte   = ops_d[1];
				if (exec_op == 8'h53 || exec_op == 8'hA3 || exec_op == 8'h57 ||
						exec_op == 8'hA7 || exec_op == 8'h59 || exec_op == 8'hA9 ||
						exec_op == 8'h5F || exec_op == 8'hAF) begin
					ev.chip_port = 7'd1;
				end else if (exec_op == slcp_pkg::OP_PWM) begin
					ev.reg_address = ops_d[0] >> 4;
					ev.data_word   = {ops_d[0], ops_d[1]} & slcp_pkg::PWM_MASK;
				end
			end
			4'd4: begin
				ev.chip_instance = ops_d[0][7];
				ev.chip_port     = 7'(ops_d[0] & slcp_pkg::PORT_MASK);
				ev.reg_address   = ops_d[1];
				ev.data_byte     = ops_d[2];
			end
			4'd5: begin
				ev.chip_instance = ops_d[0][7];
				ev.chip_port     = 7'(ops_d[0] & slcp_pkg::PORT_MASK);
				ev.reg_address   = ops_d[1];
				ev.data_byte     = ops_d[2];
				ev.data_word     = {ops_d[2], ops_d[3]};
			end
			default: ev.data_byte = 8'd0;
		endcase

		if (exec_en) begin
			if (chip.valid) begin
				emit = 1'b1;
				if (exec_op[7:4] == 4'h8) begin
					tick_inc = 16'(exec_op & slcp_pkg::NIBBLE_MASK);
				end
			end else if (exec_op == slcp_pkg::OP_WAIT_N) begin
				tick_inc = {ops_d[1], ops_d[0]};
			end else if (exec_op == slcp_pkg::OP_WAIT_735) begin
				tick_inc = slcp_pkg::WAIT_NTSC;
			end else if (exec_op == slcp_pkg::OP_WAIT_882) begin
				tick_inc = slcp_pkg::WAIT_PAL;
			end else if (exec_op[7:4] == 4'h7) begin
				tick_inc = 16'(exec_op & slcp_pkg::NIBBLE_MASK) + 16'd1;
			end
		end
		tick_d = tick_q + 32'(tick_inc);
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 4'd0;
			held_q  <= 8'd0;
			skip_q  <= 32'd0;
			tick_q  <= 32'd0;
			ended_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= 4'd0;
				held_q  <= 8'd0;
				skip_q  <= 32'd0;
				tick_q  <= 32'd0;
				ended_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				held_q  <= held_d;
				tick_q  <= tick_d;
				if (exec_en && !chip.valid && exec_op == slcp_pkg::OP_DATA_BLOCK) begin
					skip_q <= ops_d;
				end else begin
					skip_q <= skip_d;
				end
				ended_q <= ended_d || (exec_en && !chip.valid && exec_op == slcp_pkg::OP_END);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ops_q <= ops_d;
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= ev;
		end
	end

	`SLCP_ASSERT_IMP(a_ended_idle, clk, arst_n, ended_q, phase_q == 4'd0 && skip_q == 32'd0)
	`SLCP_ASSERT_IMP(a_skip_idle, clk, arst_n, skip_q != 32'd0, phase_q == 4'd0)
	`SLCP_ASSERT_NXT(a_last_reset, clk, arst_n, advance && last_s1,
		phase_q == 4'd0 && !ended_q && tick_q == 32'd0 && skip_q == 32'd0)
	`SLCP_ASSERT_IMP(a_emit_exec, clk, arst_n, emit, exec_en && chip.valid)

endmodule

// ===== tb/tb_sound_log_command_parser.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the sound log command parser: byte frames in, predicted events checked

class event_scoreboard;
	localparam int NO_CHIP = -1;

	slcp_pkg::event_t pending_events[$];
	int errors;
	int events_checked;

	int        phase;
	bit [7:0]  held_op;
	bit [7:0]  operand [4];
	bit [31:0] skip_left;
	bit [31:0] tick;
	bit        ended;

	function new();
		errors = 0;
		events_checked = 0;
		clear_state();
	endfunction

	function void clear_state();
		phase = 0;
		held_op = '0;
		foreach (operand[i]) operand[i] = '0;
		skip_left = '0;
		tick = '0;
		ended = 1'b0;
	endfunction

	function int command_length(bit [7:0] op);
		if (op < 8'h20) return 1;
		if (op == 8'h20 || op == 8'h22) return 3;
		if (op < 8'h40) return 2;
		if (op < 8'h4F) return 3;
		if (op <= 8'h50) return 2;
		if (op < 8'h60) return 3;
		if (op == slcp_pkg::OP_WAIT_N) return 3;
		if (op == slcp_pkg::OP_DATA_BLOCK) return 7;
		if (op == 8'h68) return 12;
		if (op < 8'h90) return 1;
		if (op == 8'h90) return 3;
		if (op == 8'h93) return 4;
		if (op == 8'h95) return 5;
		if (op < 8'h95) return 2;
		if (op < 8'hA0) return 1;
		if (op < 8'hC0) return 3;
		if (op < 8'hC3) return 5;
		if (op < 8'hC9) return 4;
		if (op < 8'hD0) return 1;
		if (op < 8'hD3) return 4;
		if (op < 8'hD7) return 5;
		if (op == 8'hE0 || op == 8'hE1) return 5;
		return 1;
	endfunction

	function int chip_lookup(bit [7:0] op);
		if ((op >= 8'h51 && op <= 8'h5F) || (op >= 8'hA1 && op <= 8'hAF)) begin
			case (op[3:0])
				4'h1: return 2;
				4'h2, 4'h3: return 3;
				4'h4: return 4;
				4'h5: return 5;
				4'h6, 4'h7: return 6;
				4'h8, 4'h9: return 7;
				4'hA: return 8;
				4'hB: return 9;
				4'hC: return 10;
				4'hD: return 11;
				default: return 12;
			endcase
		end
		if (op[7:4] == 4'h8) return 3;
		if (op[7:4] == 4'hB) return (op[3:0] == 4'h0) ? 13 : 12 + op[3:0];
		case (op)
			8'h20, 8'h31, 8'hA0: return 0;
			8'h30, 8'h3F, 8'h4F, 8'h50: return 1;
			8'hC0: return 28;
			8'hC1, 8'hC2: return 13;
			8'hC3: return 17;
			8'hC4: return 26;
			8'hC5, 8'hD3: return 29;
			8'hC6, 8'hD4: return 30;
			8'hC7: return 31;
			8'hC8: return 22;
			8'hD0: return 32;
			8'hD1: return 33;
			8'hD2: return 34;
			8'hE0: return 3;
			8'hE1: return 35;
			default: return NO_CHIP;
		endcase
	endfunction

	function void run_command(bit [7:0] op);
		int chip;
		slcp_pkg::event_t ev;
		chip = chip_lookup(op);
		if (chip != NO_CHIP) begin
			ev = '0;
			ev.event_tick = tick;
			ev.command_code = op;
			ev.chip_code = chip[5:0];
			ev.chip_instance = (op >= 8'hA1 && op <= 8'hAF) || (op >= 8'h30 && op <= 8'h3F);
			case (command_length(op))
				2: ev.data_byte = operand[0];
				3: begin
					ev.reg_address = operand[0];
					ev.data_byte = operand[1];
					case (op)
						8'h53, 8'hA3, 8'h57, 8'hA7,
						8'h59, 8'hA9, 8'h5F, 8'hAF: ev.chip_port = 7'd1;
						slcp_pkg::OP_PWM: begin
							ev.reg_address = {4'h0, operand[0][7:4]};
							ev.data_word = {operand[0], operand[1]} & slcp_pkg::PWM_MASK;
						end
						default: ;
					endcase
				end
				4: begin
					ev.chip_instance = operand[0][7];
					ev.chip_port = operand[0][6:0];
					ev.reg_address = operand[1];
					ev.data_byte = operand[2];
				end
				5: begin
					ev.chip_instance = operand[0][7];
					ev.chip_port = operand[0][6:0];
					ev.reg_address = operand[1];
					ev.data_byte = operand[2];
					ev.data_word = {operand[2], operand[3]};
				end
				default: ;
			endcase
			pending_events.insert(pending_events.size(), ev);
			if (op[7:4] == 4'h8) tick += op[3:0];
		end else if (op == slcp_pkg::OP_WAIT_N) begin
			tick += {operand[1], operand[0]};
		end else if (op == slcp_pkg::OP_WAIT_735) begin
			tick += slcp_pkg::WAIT_NTSC;
		end else if (op == slcp_pkg::OP_WAIT_882) begin
			tick += slcp_pkg::WAIT_PAL;
		end else if (op == slcp_pkg::OP_END) begin
			ended = 1'b1;
		end else if (op == slcp_pkg::OP_DATA_BLOCK) begin
			skip_left = {operand[3], operand[2], operand[1], operand[0]};
		end else if (op[7:4] == 4'h7) begin
			tick += op[3:0] + 1;
		end
	endfunction

	function void note_byte(bit [7:0] b, bit fin);
		if (ended) begin
		end else if (skip_left != 0) begin
			skip_left--;
		end else if (phase == 0) begin
			if (command_length(b) == 1) begin
				run_command(b);
			end else begin
				held_op = b;
				phase = 1;
			end
		end else begin
			if (held_op == slcp_pkg::OP_DATA_BLOCK) begin
				if (phase >= 3) operand[2'(phase - 3)] = b;
			end else if (phase <= 4) begin
				operand[2'(phase - 1)] = b;
			end
			phase++;
			if (phase >= command_length(held_op)) begin
				phase = 0;
				run_command(held_op);
			end
		end
		if (fin) clear_state();
	endfunction

	function int field_mismatch(string label, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			return 1;
		end
		return 0;
	endfunction

	function void check_event(logic [slcp_pkg::TDATA_W-1:0] data);
		slcp_pkg::event_t got;
		slcp_pkg::event_t want;
		int bad;
		got = data;
		if (pending_events.size() == 0) begin
			$display("%0t: unexpected event, expected none, actual %h", $time, data);
			errors++;
			return;
		end
		want = pending_events.pop_front();
		events_checked++;
		bad = 0;
		bad += field_mismatch("event_tick", want.event_tick, got.event_tick);
		bad += field_mismatch("command_code", want.command_code, got.command_code);
		bad += field_mismatch("chip_code", want.chip_code, got.chip_code);
		bad += field_mismatch("chip_instance", want.chip_instance, got.chip_instance);
		bad += field_mismatch("chip_port", want.chip_port, got.chip_port);
		bad += field_mismatch("reg_address", want.reg_address, got.reg_address);
		bad += field_mismatch("data_byte", want.data_byte, got.data_byte);
		bad += field_mismatch("data_word", want.data_word, got.data_word);
		bad += field_mismatch("zero fill", want.pad, got.pad);
		if (bad != 0) errors++;
	endfunction
endclass

module tb_sound_log_command_parser;
	localparam int BYTE_TARGET = 1450;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [7:0]                   s_axis_tdata;   // stream_byte
	logic                         s_axis_tlast;   // final_byte
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	// event_tick, command_code, chip_code, chip_instance, chip_port,
	// reg_address, data_byte, data_word, zero fill
	logic [slcp_pkg::TDATA_W-1:0] m_axis_tdata;

	event_scoreboard sb = new();

	bit [7:0] frame_bytes[$];
	int       last_cmd_start;
	int       bytes_sent = 0;
	int       frames_sent = 0;
	int       src_count = 0;
	bit       src_calm = 1'b0;

	sound_log_command_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) sb.check_event(m_axis_tdata);
		end
	end

	function automatic void append_byte(input bit [7:0] b);
		frame_bytes.insert(frame_bytes.size(), b);
	endfunction

	function automatic bit [7:0] operand_value();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_command();
		bit [7:0] op;
		int       len;
		int       k;
		k = $urandom_range(0, 9);
		if (k < 6) begin
			do op = 8'($urandom_range(0, 255));
			while (op == slcp_pkg::OP_END || op == slcp_pkg::OP_DATA_BLOCK);
		end else if (k == 6) begin
			op = 8'h80 | 8'($urandom_range(0, 15));
		end else if (k == 7) begin
			case ($urandom_range(0, 3))
				0: op = slcp_pkg::OP_WAIT_N;
				1: op = slcp_pkg::OP_WAIT_735;
				2: op = slcp_pkg::OP_WAIT_882;
				default: op = 8'h70 | 8'($urandom_range(0, 15));
			endcase
		end else if (k == 8) begin
			op = slcp_pkg::OP_DATA_BLOCK;
		end else begin
			if ($urandom_range(0, 1) != 0) op = 8'($urandom_range(8'hC0, 8'hD6));
			else op = 8'hE0 | 8'($urandom_range(0, 1));
		end
		last_cmd_start = frame_bytes.size();
		append_byte(op);
		if (op == slcp_pkg::OP_DATA_BLOCK) begin
			len = $urandom_range(0, 8);
			append_byte(8'h66);
			append_byte(8'($urandom_range(0, 255)));
			append_byte(len[7:0]);
			repeat (3) append_byte(8'h00);
			repeat (len) append_byte(8'($urandom_range(0, 255)));
		end else begin
			len = sb.command_length(op);
			repeat (len - 1) append_byte(operand_value());
		end
	endfunction

	task automatic send_byte(input bit [7:0] b, input bit fin);
		int gap;
		if (src_count % 50 == 0) src_calm = ($urandom_range(0, 3) == 0);
		src_count++;
		gap = src_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		do @(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frames_sent++;
	endtask

	initial begin
		int cmd_bytes = 0;
		int kind;
		int keep;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the one-, two-, three- and five-byte command shapes, both instances, skip, end and trailing byte
		frame_bytes = '{8'h4F, 8'h00, 8'hA7, 8'hFF, 8'h80, 8'h61, 8'hFF, 8'hFF, 8'h8F,
			8'hB2, 8'hFF, 8'hFF, 8'h67, 8'h66, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
			8'hAA, 8'hBB, 8'hE1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h66, 8'h12};
		send_frame();

		while (bytes_sent < BYTE_TARGET) begin
			frame_bytes.delete();
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 30)) append_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 30)) add_command();
				cmd_bytes += frame_bytes.size();
				if (kind <= 6) begin
					append_byte(slcp_pkg::OP_END);
					repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
				end else if (kind == 9 && frame_bytes.size() - last_cmd_start >= 2) begin
					keep = last_cmd_start + $urandom_range(1, frame_bytes.size() - last_cmd_start - 1);
					while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
				end
			end
			send_frame();
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d frames, %0d bytes (%0d in commands), %0d events checked",
			frames_sent, bytes_sent, cmd_bytes, sb.events_checked);
		$display("includes end commands, truncated last commands, data-block skips and noise frames");
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		int  stall;
		int  sink_count = 0;
		bit  sink_calm = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			if (sink_count % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
			sink_count++;
			stall = sink_calm ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end
endmodule
